>>> rtl/aabb_pkg.sv
// Package for the box push-out resolver: command codes, register indexes,
// position limits and the queue entry type. No dependencies.
package aabb_pkg;

  // Field widths of the item and result beats.
  localparam int POS_W   = 21;
  localparam int EDGE_W  = 20;
  localparam int SIZE_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  // Widths of the values the front part hands to the back part and of the back part's differences.
  localparam int CENT_W  = 23;  // 2*edge + size - box size, 1/32 pixel
  localparam int DIFF_W  = 24;  // position minus obstacle term
  localparam int MAG_W   = 23;  // magnitude of the difference
  localparam int HALF_W  = 17;  // sum of two sizes

  // Item function codes.
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_RESOLVE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 1'b1;

  // Reset values of the box size registers.
  localparam logic [CFG_W-1:0] BOX_SIZE_RESET = 16'd512;

  // Position range.
  localparam logic signed [POS_W-1:0] POS_MAX = 21'sh0FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 21'sh100000;

  // Axis codes of the moved_axis result field.
  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  // One classified item waiting in the queue.
  typedef struct packed {
    logic                     is_load;
    logic                     last;
    logic signed [POS_W-1:0]  load_x;
    logic signed [POS_W-1:0]  load_y;
    logic signed [CENT_W-1:0] cent_x;
    logic signed [CENT_W-1:0] cent_y;
    logic [HALF_W-1:0]        half_x;
    logic [HALF_W-1:0]        half_y;
  } cmd_t;

  // Queue status seen by the two sides.
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

>>> rtl/aabb_if.sv
// Valid/ready channel interfaces for item beats and result beats.
// Depends on aabb_pkg for the field widths.
interface aabb_item_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic signed [aabb_pkg::POS_W-1:0]    load_x;
  logic signed [aabb_pkg::POS_W-1:0]    load_y;
  logic signed [aabb_pkg::EDGE_W-1:0]   obstacle_x;
  logic signed [aabb_pkg::EDGE_W-1:0]   obstacle_y;
  logic [aabb_pkg::SIZE_W-1:0]          obstacle_w;
  logic [aabb_pkg::SIZE_W-1:0]          obstacle_h;
  logic                                 last_obstacle;

  modport source (output valid, func, load_x, load_y, obstacle_x, obstacle_y,
                  obstacle_w, obstacle_h, last_obstacle, input ready);
  modport sink   (input valid, func, load_x, load_y, obstacle_x, obstacle_y,
                  obstacle_w, obstacle_h, last_obstacle, output ready);
endinterface

interface aabb_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [aabb_pkg::POS_W-1:0] pos_x;
  logic signed [aabb_pkg::POS_W-1:0] pos_y;
  logic                              hit;
  logic                              moved_axis;
  logic                              last_result;
  logic                              saturated;

  modport source (output valid, pos_x, pos_y, hit, moved_axis, last_result,
                  saturated, input ready);
  modport sink   (input valid, pos_x, pos_y, hit, moved_axis, last_result,
                  saturated, output ready);
endinterface

>>> rtl/aabb_front.sv
// Front part: takes item beats, folds in the box size registers and builds
// the queue entry. Depends on aabb_pkg and aabb_if.
module aabb_front (
  aabb_item_if.sink                        item,
  input  logic [aabb_pkg::CFG_W-1:0]       box_width,
  input  logic [aabb_pkg::CFG_W-1:0]       box_height,
  input  aabb_pkg::queue_status_t          q_status,
  output logic                             push,
  output aabb_pkg::cmd_t                   cmd
);

  localparam int EXT_W = aabb_pkg::CENT_W - aabb_pkg::EDGE_W;
  localparam int PAD_W = aabb_pkg::CENT_W - aabb_pkg::SIZE_W;

  logic signed [aabb_pkg::CENT_W-1:0] edge_x2;
  logic signed [aabb_pkg::CENT_W-1:0] edge_y2;

  // A beat is taken whenever the queue has room.
  assign item.ready = !q_status.full;
  assign push       = item.valid && !q_status.full;

  // Obstacle edges doubled into 1/32 pixel.
  assign edge_x2 = {{(EXT_W-1){item.obstacle_x[aabb_pkg::EDGE_W-1]}}, item.obstacle_x, 1'b0};
  assign edge_y2 = {{(EXT_W-1){item.obstacle_y[aabb_pkg::EDGE_W-1]}}, item.obstacle_y, 1'b0};

  // The back part only needs pos minus this term to get the centre difference.
  always_comb begin
    cmd.is_load = (item.func == aabb_pkg::FUNC_LOAD);
    cmd.last    = item.last_obstacle;
    cmd.load_x  = item.load_x;
    cmd.load_y  = item.load_y;
    cmd.cent_x  = edge_x2 + $signed({{PAD_W{1'b0}}, item.obstacle_w})
                          - $signed({{PAD_W{1'b0}}, box_width});
    cmd.cent_y  = edge_y2 + $signed({{PAD_W{1'b0}}, item.obstacle_h})
                          - $signed({{PAD_W{1'b0}}, box_height});
    cmd.half_x  = {1'b0, box_width}  + {1'b0, item.obstacle_w};
    cmd.half_y  = {1'b0, box_height} + {1'b0, item.obstacle_h};
  end

endmodule

>>> rtl/aabb_queue.sv
// Short queue of classified items between the front and back parts.
// Depends on aabb_pkg for the entry type.
module aabb_queue #(
  parameter int DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  aabb_pkg::cmd_t          push_cmd,
  input  logic                    pop,
  output aabb_pkg::cmd_t          head,
  output aabb_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  aabb_pkg::cmd_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == FULL_COUNT);
  assign status.valid = (count != '0);
  assign head         = entries[rd_ptr];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers wrap at the depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/aabb_back.sv
// Back part: holds the box position and resolves one queued item per cycle,
// unless its registered result stalls. Depends on aabb_pkg and aabb_if.
module aabb_back (
  input  logic                    clk,
  input  logic                    rst,
  input  aabb_pkg::cmd_t          head,
  input  aabb_pkg::queue_status_t q_status,
  output logic                    pop,
  aabb_result_if.source           result
);

  localparam int P  = aabb_pkg::POS_W;
  localparam int NP = aabb_pkg::POS_W + 1;

  logic signed [P-1:0]                    box_pos_x;
  logic signed [P-1:0]                    box_pos_y;
  logic signed [aabb_pkg::DIFF_W-1:0]     dx;
  logic signed [aabb_pkg::DIFF_W-1:0]     dy;
  logic [aabb_pkg::MAG_W-1:0]             mag_x;
  logic [aabb_pkg::MAG_W-1:0]             mag_y;
  logic                                   overlap;
  logic [aabb_pkg::HALF_W-1:0]            pen_x;
  logic [aabb_pkg::HALF_W-1:0]            pen_y;
  logic                                   push_y;
  logic signed [NP-1:0]                   base;
  logic signed [NP-1:0]                   step;
  logic                                   step_up;
  logic signed [NP-1:0]                   moved;
  logic                                   clip;
  logic signed [P-1:0]                    moved_clip;

  // Take the head when the result register is empty or being emptied.
  assign pop = q_status.valid && (!result.valid || result.ready);

  // Centre differences and their magnitudes.
  assign dx    = $signed({{3{box_pos_x[P-1]}}, box_pos_x}) - $signed({head.cent_x[aabb_pkg::CENT_W-1], head.cent_x});
  assign dy    = $signed({{3{box_pos_y[P-1]}}, box_pos_y}) - $signed({head.cent_y[aabb_pkg::CENT_W-1], head.cent_y});
  assign mag_x = dx[aabb_pkg::DIFF_W-1] ? aabb_pkg::MAG_W'(-dx) : aabb_pkg::MAG_W'(dx);
  assign mag_y = dy[aabb_pkg::DIFF_W-1] ? aabb_pkg::MAG_W'(-dy) : aabb_pkg::MAG_W'(dy);

  // Strict overlap test on both axes.
  assign overlap = (mag_x < {{(aabb_pkg::MAG_W-aabb_pkg::HALF_W){1'b0}}, head.half_x})
                && (mag_y < {{(aabb_pkg::MAG_W-aabb_pkg::HALF_W){1'b0}}, head.half_y});

  // Penetration depths are only meaningful on overlap, where they fit.
  assign pen_x  = head.half_x - mag_x[aabb_pkg::HALF_W-1:0];
  assign pen_y  = head.half_y - mag_y[aabb_pkg::HALF_W-1:0];
  assign push_y = !(pen_x < pen_y);

  // Push along the chosen axis, away from the obstacle centre.
  always_comb begin
    if (push_y) begin
      base    = {box_pos_y[P-1], box_pos_y};
      step    = $signed({{(NP-aabb_pkg::HALF_W){1'b0}}, pen_y});
      step_up = !dy[aabb_pkg::DIFF_W-1] && (dy != '0);
    end else begin
      base    = {box_pos_x[P-1], box_pos_x};
      step    = $signed({{(NP-aabb_pkg::HALF_W){1'b0}}, pen_x});
      step_up = !dx[aabb_pkg::DIFF_W-1] && (dx != '0);
    end
    moved = step_up ? base + step : base - step;
  end

  // Clip to the position range; overflow shows as differing top bits.
  assign clip       = (moved[NP-1] != moved[NP-2]);
  assign moved_clip = clip ? (moved[NP-1] ? aabb_pkg::POS_MIN : aabb_pkg::POS_MAX)
                           : moved[P-1:0];

  // Position state.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_pos_x <= '0;
      box_pos_y <= '0;
    end else if (pop) begin
      if (head.is_load) begin
        box_pos_x <= head.load_x;
        box_pos_y <= head.load_y;
      end else if (overlap) begin
        if (push_y) begin
          box_pos_y <= moved_clip;
        end else begin
          box_pos_x <= moved_clip;
        end
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (pop) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // Result payload, reflecting the position after this item.
  always_ff @(posedge clk) begin
    if (pop) begin
      result.last_result <= head.last;
      if (head.is_load) begin
        result.pos_x      <= head.load_x;
        result.pos_y      <= head.load_y;
        result.hit        <= 1'b0;
        result.moved_axis <= aabb_pkg::AXIS_X;
        result.saturated  <= 1'b0;
      end else if (overlap) begin
        result.pos_x      <= push_y ? box_pos_x : moved_clip;
        result.pos_y      <= push_y ? moved_clip : box_pos_y;
        result.hit        <= 1'b1;
        result.moved_axis <= push_y ? aabb_pkg::AXIS_Y : aabb_pkg::AXIS_X;
        result.saturated  <= clip;
      end else begin
        result.pos_x      <= box_pos_x;
        result.pos_y      <= box_pos_y;
        result.hit        <= 1'b0;
        result.moved_axis <= aabb_pkg::AXIS_X;
        result.saturated  <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/aabb_push_out_resolver_top.sv
// Box push-out resolver, one result beat per item beat: a load beat sets the
// box position, a resolve beat pushes the box out of one obstacle along the
// axis of smaller overlap. It sustains one item per clock while results are
// not stalled. The front classifies an item combinationally into the queue
// as it is accepted; the back resolves the queue head against the position
// register, whose feedback loop sets the rate, and registers the result.
// The queue holds QUEUE_DEPTH items (a power of two, 2 or more) so items
// are taken while a result stalls, until full. The user writes the size
// registers via cfg_we/cfg_index/cfg_wdata only while idle (not enforced).
// Depends on aabb_pkg, aabb_if, aabb_front, aabb_queue and aabb_back.
module aabb_push_out_resolver_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [aabb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aabb_pkg::CFG_W-1:0]          cfg_wdata,
  aabb_item_if.sink                           item,
  aabb_result_if.source                       result
);

  logic [aabb_pkg::CFG_W-1:0] box_width;
  logic [aabb_pkg::CFG_W-1:0] box_height;
  aabb_pkg::queue_status_t    q_status;
  aabb_pkg::cmd_t             push_cmd;
  aabb_pkg::cmd_t             head;
  logic                       push;
  logic                       pop;

  // Box size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_width  <= aabb_pkg::BOX_SIZE_RESET;
      box_height <= aabb_pkg::BOX_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        aabb_pkg::REG_BOX_WIDTH:  box_width  <= cfg_wdata;
        aabb_pkg::REG_BOX_HEIGHT: box_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  aabb_front u_front (
    .item       (item),
    .box_width  (box_width),
    .box_height (box_height),
    .q_status   (q_status),
    .push       (push),
    .cmd        (push_cmd)
  );

  aabb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  aabb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .result   (result)
  );

endmodule

>>> rtl/aabb_checker.sv
// Port-level checks for the box push-out resolver, bound to the top level.
// Depends on aabb_pkg and aabb_push_out_resolver_top.
module aabb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [aabb_pkg::POS_W-1:0] pos_x,
  input logic signed [aabb_pkg::POS_W-1:0] pos_y,
  input logic                              hit,
  input logic                              moved_axis,
  input logic                              saturated
);

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pos_x) && $stable(pos_y) && $stable(hit))
    else $error("result beat changed while stalled");

  // No axis is reported without a push.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> moved_axis == aabb_pkg::AXIS_X)
    else $error("moved_axis set without a hit");

  // Clipping can only follow a push.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> !saturated)
    else $error("saturated set without a hit");

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind aabb_push_out_resolver_top aabb_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .pos_x      (result.pos_x),
  .pos_y      (result.pos_y),
  .hit        (result.hit),
  .moved_axis (result.moved_axis),
  .saturated  (result.saturated)
);
